FILE: src/two_list_merge_core_defines.svh
// Assertion macros for the merge sequencer.
`ifndef TWO_LIST_MERGE_CORE_DEFINES_SVH
`define TWO_LIST_MERGE_CORE_DEFINES_SVH

// Same-cycle implication, disabled while in reset
`define TLM_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset
`define TLM_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/tlm_pkg.sv
package tlm_pkg;

  // default list capacity
  localparam int unsigned LIST_DEPTH = 16;
  localparam int unsigned VALUE_W    = 32;

  // action codes
  localparam logic [1:0] ACT_LOAD_A = 2'd0;
  localparam logic [1:0] ACT_LOAD_B = 2'd1;
  localparam logic [1:0] ACT_MERGE  = 2'd2;

  typedef struct packed {
    logic [1:0]                 action;
    logic signed [VALUE_W-1:0]  value;
  } in_item_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0]  value_res;
    logic                       last;
  } out_item_t;

  // list buffer control from the sequencer
  typedef struct packed {
    logic push;
    logic clr;
  } buf_ctrl_t;

endpackage

FILE: src/two_list_merge_core.sv
// Two sorted-list merge core.
// Input channel (in_valid / in_stall / in_data): each transaction carries an
// action and a signed 32-bit value. Load A and load B append the value to
// the chosen list; loads into a full list are dropped. Action code 3 is
// ignored.
// A merge transaction emits every stored element on the result channel
// (out_valid / out_stall / out_data), smaller head first, ties from list B,
// then the leftovers; the final result carries last. Both lists are then
// empty. A merge of two empty lists gives no result.
// Merge steps, set by the registered read port of the list storage: after
// acceptance, for each element the sequencer first addresses the list
// heads, then compares them and registers the result.
// in_stall stays high from merge acceptance until the last result has been
// loaded into the output register; loads may follow while it waits.
// When the receiver stalls, the output register holds its result and the
// merge waits in its compare step.
// Reset (rst_n low, synchronous) empties both lists and drops any pending
// result.
module two_list_merge_core #(
  parameter int unsigned LIST_DEPTH = tlm_pkg::LIST_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  tlm_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output tlm_pkg::out_item_t out_data
);

  localparam int unsigned CNT_W = $clog2(LIST_DEPTH + 1);
  localparam int unsigned IDX_W = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;

  tlm_pkg::buf_ctrl_t                 ctrl_a, ctrl_b;
  logic [IDX_W-1:0]                   rd_addr_a, rd_addr_b;
  logic [CNT_W-1:0]                   cnt_a, cnt_b;
  logic signed [tlm_pkg::VALUE_W-1:0] rd_a, rd_b;

  // list storage
  tlm_list_buf #(.DEPTH(LIST_DEPTH)) u_list_a (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl     (ctrl_a),
    .wr_value (in_data.value),
    .rd_addr  (rd_addr_a),
    .count    (cnt_a),
    .rd_data  (rd_a)
  );

  tlm_list_buf #(.DEPTH(LIST_DEPTH)) u_list_b (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl     (ctrl_b),
    .wr_value (in_data.value),
    .rd_addr  (rd_addr_b),
    .count    (cnt_b),
    .rd_data  (rd_b)
  );

  // sequencer with the shared compare unit
  tlm_merge_seq #(.DEPTH(LIST_DEPTH)) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .ctrl_a    (ctrl_a),
    .ctrl_b    (ctrl_b),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (rd_addr_b),
    .cnt_a     (cnt_a),
    .cnt_b     (cnt_b),
    .rd_a      (rd_a),
    .rd_b      (rd_b)
  );

endmodule

FILE: src/tlm_list_buf.sv
module tlm_list_buf #(
  parameter int unsigned DEPTH = tlm_pkg::LIST_DEPTH,
  localparam int unsigned CNT_W = $clog2(DEPTH + 1),
  localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  tlm_pkg::buf_ctrl_t                ctrl,
  input  logic signed [tlm_pkg::VALUE_W-1:0] wr_value,
  input  logic [IDX_W-1:0]                  rd_addr,
  output logic [CNT_W-1:0]                  count,
  output logic signed [tlm_pkg::VALUE_W-1:0] rd_data
);

  logic signed [tlm_pkg::VALUE_W-1:0] mem [DEPTH];
  logic [CNT_W-1:0]                   count_r, count_nxt;
  logic signed [tlm_pkg::VALUE_W-1:0] rd_data_r;
  logic                               wr_en;

  // append only while there is room
  assign wr_en = ctrl.push && (count_r < CNT_W'(DEPTH));

  always_comb begin
    count_nxt = count_r;
    if (ctrl.clr) begin
      count_nxt = '0;
    end else if (wr_en) begin
      count_nxt = count_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  // storage: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[count_r[IDX_W-1:0]] <= wr_value;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign count   = count_r;
  assign rd_data = rd_data_r;

endmodule

FILE: src/tlm_merge_seq.sv
`include "two_list_merge_core_defines.svh"

module tlm_merge_seq #(
  parameter int unsigned DEPTH = tlm_pkg::LIST_DEPTH,
  localparam int unsigned CNT_W = $clog2(DEPTH + 1),
  localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  tlm_pkg::in_item_t                 in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output tlm_pkg::out_item_t                out_data,
  output tlm_pkg::buf_ctrl_t                ctrl_a,
  output tlm_pkg::buf_ctrl_t                ctrl_b,
  output logic [IDX_W-1:0]                  rd_addr_a,
  output logic [IDX_W-1:0]                  rd_addr_b,
  input  logic [CNT_W-1:0]                  cnt_a,
  input  logic [CNT_W-1:0]                  cnt_b,
  input  logic signed [tlm_pkg::VALUE_W-1:0] rd_a,
  input  logic signed [tlm_pkg::VALUE_W-1:0] rd_b
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_READ = 3'b010,
    ST_PICK = 3'b100
  } state_t;

  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   ia_r, ia_nxt, ib_r, ib_nxt;
  logic               out_valid_r, out_valid_nxt;
  tlm_pkg::out_item_t out_data_r, out_data_nxt;

  logic in_acc, out_free, a_left, b_left, take_a, emit, done;

  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  // shared compare unit on the two registered heads
  assign a_left = (ia_r < cnt_a);
  assign b_left = (ib_r < cnt_b);
  assign take_a = a_left && (!b_left || (rd_a < rd_b));
  assign emit   = (state_r == ST_PICK) && out_free;
  assign done   = ((take_a ? ia_r + CNT_W'(1) : ia_r) == cnt_a) &&
                  ((take_a ? ib_r : ib_r + CNT_W'(1)) == cnt_b);

  always_comb begin
    state_nxt     = state_r;
    ia_nxt        = ia_r;
    ib_nxt        = ib_r;
    ctrl_a        = '0;
    ctrl_b        = '0;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          case (in_data.action)
            tlm_pkg::ACT_LOAD_A: ctrl_a.push = 1'b1;
            tlm_pkg::ACT_LOAD_B: ctrl_b.push = 1'b1;
            tlm_pkg::ACT_MERGE: begin
              // an empty merge yields nothing
              if ((cnt_a != '0) || (cnt_b != '0)) begin
                ia_nxt    = '0;
                ib_nxt    = '0;
                state_nxt = ST_READ;
              end
            end
            default: ;
          endcase
        end
      end
      ST_READ: state_nxt = ST_PICK;
      ST_PICK: begin
        if (emit) begin
          out_valid_nxt          = 1'b1;
          out_data_nxt.value_res = take_a ? rd_a : rd_b;
          out_data_nxt.last      = done;
          if (take_a) begin
            ia_nxt = ia_r + CNT_W'(1);
          end else begin
            ib_nxt = ib_r + CNT_W'(1);
          end
          if (done) begin
            ctrl_a.clr = 1'b1;
            ctrl_b.clr = 1'b1;
            state_nxt  = ST_IDLE;
          end else begin
            state_nxt = ST_READ;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      ia_r        <= '0;
      ib_r        <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      ia_r        <= ia_nxt;
      ib_r        <= ib_nxt;
    end
  end

  // result register, no reset needed
  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign rd_addr_a = ia_r[IDX_W-1:0];
  assign rd_addr_b = ib_r[IDX_W-1:0];
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // checks
  `TLM_ASSERT_IMP(a_idx_in_range, state_r != ST_IDLE, (ia_r <= cnt_a) && (ib_r <= cnt_b), "merge index past list end")
  `TLM_ASSERT_NXT(a_cnt_hold, state_r == ST_READ, $stable(cnt_a) && $stable(cnt_b), "list count moved mid-merge")
  `TLM_ASSERT_NXT(a_last_clears, emit && done, (state_r == ST_IDLE) && (cnt_a == '0) && (cnt_b == '0), "lists not emptied after last result")
  `TLM_ASSERT_IMP(a_pick_has_work, state_r == ST_PICK, a_left || b_left, "pick with both lists exhausted")

endmodule
